@@ rtl/core/frcb_pkg.sv @@
// Shared constants for the floppy read/write command builder.
package frcb_pkg;

  localparam int SPT_W    = 6;
  localparam int HDS_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int BYTE_W   = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 1'b1;

  localparam logic [SPT_W-1:0] SPT_RESET   = 6'd9;
  localparam logic [HDS_W-1:0] HDS_RESET   = 2'd2;

  localparam logic [BYTE_W-1:0] OPC_READ  = 8'hE6;
  localparam logic [BYTE_W-1:0] OPC_WRITE = 8'hC5;
  localparam logic [BYTE_W-1:0] GAP_BYTE  = 8'h1B;
  localparam logic [BYTE_W-1:0] CMD_END   = 8'hFF;
  localparam logic [BYTE_W-1:0] SIZE_CODE = 8'h02;

  // The gap byte is only sent for this track length.
  localparam logic [SPT_W-1:0] GAP_SPT = 6'd18;

endpackage

@@ rtl/core/floppy_rw_command_builder.sv @@
// Floppy read/write command builder: pipelined block-to-CHS split and command byte serializer.
// Throughput: one byte per cycle on the output port while out_stall_i is low, giving 8 bytes
// per request, or 9 when sectors per track is 18; the division pipeline takes a request every
// cycle until it fills.
// Reset clears the pipeline and serializer and sets sectors per track to 9 and heads to 2.
module floppy_rw_command_builder #(
  parameter int BLOCK_WIDTH = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [BLOCK_WIDTH-1:0]            block_i,
  // Command byte channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [frcb_pkg::BYTE_W-1:0]       cmd_byte_o,
  output logic                              last_o,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [frcb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [frcb_pkg::SPT_W-1:0]        cfg_data_i
);

  localparam int W     = BLOCK_WIDTH;
  localparam int SPT_W = frcb_pkg::SPT_W;
  localparam int HDS_W = frcb_pkg::HDS_W;
  localparam int STEP1 = 4;   // quotient bits per stage when dividing by sectors per track
  localparam int STEP2 = 8;   // quotient bits per stage when dividing by heads
  localparam int NS1   = (W + STEP1 - 1) / STEP1;
  localparam int NS2   = (W + STEP2 - 1) / STEP2;
  localparam int NS    = NS1 + NS2;

  // Serializer byte positions.
  localparam logic [3:0] BYTE_OPC   = 4'd0;
  localparam logic [3:0] BYTE_HSH   = 4'd1;
  localparam logic [3:0] BYTE_TRK   = 4'd2;
  localparam logic [3:0] BYTE_HEAD  = 4'd3;
  localparam logic [3:0] BYTE_SEC   = 4'd4;
  localparam logic [3:0] BYTE_SIZE  = 4'd5;
  localparam logic [3:0] BYTE_SPT   = 4'd6;
  localparam logic [3:0] BYTE_GAP   = 4'd7;
  localparam logic [3:0] BYTE_END   = 4'd8;

  // Configuration registers.
  logic [SPT_W-1:0] spt_q;
  logic [HDS_W-1:0] heads_q;
  logic [SPT_W-1:0] spt_eff;
  logic [HDS_W-1:0] heads_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= frcb_pkg::SPT_RESET;
      heads_q <= frcb_pkg::HDS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        frcb_pkg::CFG_SPT:   spt_q   <= cfg_data_i;
        frcb_pkg::CFG_HEADS: heads_q <= cfg_data_i[HDS_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero geometry value divides as one.
  assign spt_eff   = (spt_q == '0) ? SPT_W'(1) : spt_q;
  assign heads_eff = (heads_q == '0) ? HDS_W'(1) : heads_q;

  // Division pipeline. The first NS1 stages divide the block by sectors per track, leaving
  // the cylinder-relative quotient in work and the sector remainder in r1. The remaining
  // stages divide that quotient by the head count, leaving the track in work and the head in r2.
  logic             valid_q [NS];
  logic             op_q    [NS];
  logic [W-1:0]     work_q  [NS];
  logic [SPT_W-1:0] r1_q    [NS];
  logic [HDS_W-1:0] r2_q    [NS];

  logic             valid_in [NS];
  logic             op_in    [NS];
  logic [W-1:0]     work_in  [NS];
  logic [SPT_W-1:0] r1_in    [NS];
  logic [HDS_W-1:0] r2_in    [NS];

  logic [W-1:0]     work_c   [NS];
  logic [SPT_W-1:0] r1_c     [NS];
  logic [HDS_W-1:0] r2_c     [NS];

  logic [NS:0]      adv;
  logic             ser_ready;

  assign adv[NS]    = ser_ready;
  assign in_stall_o = !adv[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam bit IS_D1 = (s < NS1);
    localparam int FIRST = IS_D1 ? s * STEP1 : (s - NS1) * STEP2;
    localparam int NSTEP = IS_D1 ? ((W - FIRST < STEP1) ? W - FIRST : STEP1)
                                 : ((W - FIRST < STEP2) ? W - FIRST : STEP2);

    if (s == 0) begin : g_head
      assign valid_in[s] = in_valid_i;
      assign op_in[s]    = op_i;
      assign work_in[s]  = block_i;
      assign r1_in[s]    = '0;
      assign r2_in[s]    = '0;
    end else begin : g_link
      assign valid_in[s] = valid_q[s-1];
      assign op_in[s]    = op_q[s-1];
      assign work_in[s]  = work_q[s-1];
      assign r1_in[s]    = r1_q[s-1];
      assign r2_in[s]    = r2_q[s-1];
    end

    assign adv[s] = !valid_q[s] || adv[s+1];

    if (IS_D1) begin : g_div_spt
      logic [SPT_W:0] t1;
      logic [SPT_W:0] diff1;

      always_comb begin
        work_c[s] = work_in[s];
        r1_c[s]   = r1_in[s];
        r2_c[s]   = r2_in[s];
        t1        = '0;
        diff1     = '0;
        for (int k = 0; k < NSTEP; k++) begin
          t1    = {r1_c[s], work_c[s][W-1]};
          diff1 = t1 - {1'b0, spt_eff};
          if (t1 >= {1'b0, spt_eff}) begin
            r1_c[s]   = diff1[SPT_W-1:0];
            work_c[s] = {work_c[s][W-2:0], 1'b1};
          end else begin
            r1_c[s]   = t1[SPT_W-1:0];
            work_c[s] = {work_c[s][W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_div_heads
      logic [HDS_W:0] t2;
      logic [HDS_W:0] diff2;

      always_comb begin
        work_c[s] = work_in[s];
        r1_c[s]   = r1_in[s];
        r2_c[s]   = r2_in[s];
        t2        = '0;
        diff2     = '0;
        for (int k = 0; k < NSTEP; k++) begin
          t2    = {r2_c[s], work_c[s][W-1]};
          diff2 = t2 - {1'b0, heads_eff};
          if (t2 >= {1'b0, heads_eff}) begin
            r2_c[s]   = diff2[HDS_W-1:0];
            work_c[s] = {work_c[s][W-2:0], 1'b1};
          end else begin
            r2_c[s]   = t2[HDS_W-1:0];
            work_c[s] = {work_c[s][W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv[s]) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        op_q[s]   <= op_in[s];
        work_q[s] <= work_c[s];
        r1_q[s]   <= r1_c[s];
        r2_q[s]   <= r2_c[s];
      end
    end
  end

  // Serializer: holds one decoded request and sends its command bytes one per transfer.
  logic             ser_valid_q;
  logic [3:0]       idx_q;
  logic [3:0]       idx_d;
  logic             ser_op_q;
  logic [7:0]       ser_track_q;
  logic [HDS_W-1:0] ser_head_q;
  logic [SPT_W-1:0] ser_sector_q;
  logic             out_xfer;
  logic             ser_load;

  assign out_valid_o = ser_valid_q;
  assign last_o      = (idx_q == BYTE_END);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign ser_ready   = !ser_valid_q || (out_xfer && last_o);
  assign ser_load    = ser_ready && valid_q[NS-1];

  always_comb begin
    case (idx_q)
      BYTE_SPT: idx_d = (spt_q == frcb_pkg::GAP_SPT) ? BYTE_GAP : BYTE_END;
      default:  idx_d = idx_q + 4'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      idx_q       <= BYTE_OPC;
    end else if (ser_ready) begin
      ser_valid_q <= valid_q[NS-1];
      idx_q       <= BYTE_OPC;
    end else if (out_xfer) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_op_q     <= op_q[NS-1];
      ser_track_q  <= work_q[NS-1][7:0];
      ser_head_q   <= r2_q[NS-1];
      // Sectors are numbered from one; the remainder is below 63, so this cannot wrap.
      ser_sector_q <= r1_q[NS-1] + SPT_W'(1);
    end
  end

  always_comb begin
    case (idx_q)
      BYTE_OPC:  cmd_byte_o = ser_op_q ? frcb_pkg::OPC_WRITE : frcb_pkg::OPC_READ;
      BYTE_HSH:  cmd_byte_o = {4'b0000, ser_head_q, 2'b00};
      BYTE_TRK:  cmd_byte_o = ser_track_q;
      BYTE_HEAD: cmd_byte_o = {6'b000000, ser_head_q};
      BYTE_SEC:  cmd_byte_o = {2'b00, ser_sector_q};
      BYTE_SIZE: cmd_byte_o = frcb_pkg::SIZE_CODE;
      BYTE_SPT:  cmd_byte_o = {2'b00, spt_q};
      BYTE_GAP:  cmd_byte_o = frcb_pkg::GAP_BYTE;
      BYTE_END:  cmd_byte_o = frcb_pkg::CMD_END;
      default:   cmd_byte_o = '0;
    endcase
  end

endmodule

@@ verif/frcb_command_checker.sv @@
// Checker that predicts and compares the command bytes of the floppy command builder.
module frcb_command_checker #(
  parameter int BLOCK_WIDTH = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           op_i,
  input  logic [BLOCK_WIDTH-1:0]         block_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [frcb_pkg::BYTE_W-1:0]    cmd_byte_i,
  input  logic                           last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [frcb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frcb_pkg::SPT_W-1:0]     cfg_data_i,
  output int                             pending_o,
  output int                             fail_count_o,
  output int                             bytes_seen_o
);
  import frcb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } cmd_byte_t;

  cmd_byte_t         bytes_due[$];
  logic [SPT_W-1:0]  spt_reg;
  logic [HDS_W-1:0]  heads_reg;
  int                errors;
  int                seen;

  function automatic void due(input logic [BYTE_W-1:0] value, input logic last);
    bytes_due.push_back('{value, last});
  endfunction

  // Splits the block into track, head and sector and queues the command bytes it yields.
  function automatic void queue_command(input logic wr, input logic [BLOCK_WIDTH-1:0] blk);
    int unsigned spt;
    int unsigned heads;
    int unsigned cyl;
    int unsigned track;
    int unsigned head;
    spt   = (spt_reg == '0) ? 1 : 32'(spt_reg);
    heads = (heads_reg == '0) ? 1 : 32'(heads_reg);
    cyl   = spt * heads;
    track = blk / cyl;
    head  = (blk % cyl) / spt;
    due(wr ? OPC_WRITE : OPC_READ, 1'b0);
    due(BYTE_W'(head << 2), 1'b0);
    due(BYTE_W'(track), 1'b0);
    due(BYTE_W'(head), 1'b0);
    due(BYTE_W'(blk % spt + 1), 1'b0);
    due(SIZE_CODE, 1'b0);
    due({2'b00, spt_reg}, 1'b0);
    if (spt_reg == GAP_SPT) begin
      due(GAP_BYTE, 1'b0);
    end
    due(CMD_END, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_byte_t exp_byte;
    if (!rst_ni) begin
      bytes_due.delete();
      spt_reg      = SPT_RESET;
      heads_reg    = HDS_RESET;
      errors       = 0;
      seen         = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      bytes_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPT:   spt_reg = cfg_data_i;
          CFG_HEADS: heads_reg = cfg_data_i[HDS_W-1:0];
          default:   ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (bytes_due.size() == 0) begin
          $error("cmd_byte: no byte expected, got %02h (last %0b)", cmd_byte_i, last_i);
          errors++;
        end else begin
          exp_byte = bytes_due.pop_front();
          if (cmd_byte_i !== exp_byte.value) begin
            $error("cmd_byte: expected %02h, got %02h", exp_byte.value, cmd_byte_i);
            errors++;
          end
          if (last_i !== exp_byte.last) begin
            $error("last: expected %0b, got %0b", exp_byte.last, last_i);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        queue_command(op_i, block_i);
      end
      pending_o    <= bytes_due.size();
      fail_count_o <= errors;
      bytes_seen_o <= seen;
    end
  end

endmodule

@@ verif/tb.sv @@
// Top of the command builder testbench: reset, stimulus, stalls, watchdog and verdict.
module tb;
  import frcb_pkg::*;

  localparam int          BLOCK_W        = 13;
  localparam int          RANDOM_ITEMS   = 250;
  localparam int          HOLD_CYCLES    = 60;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic        OP_READ        = 1'b0;
  localparam logic        OP_WRITE       = 1'b1;
  localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 op          = OP_READ;
  logic [BLOCK_W-1:0]   block       = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [BYTE_W-1:0]    cmd_byte;
  logic                 last;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_SPT;
  logic [SPT_W-1:0]     cfg_data    = '0;

  int                   pending;
  int                   fail_count;
  int                   bytes_seen;

  // Stimulus controls shared with the receiver process.
  bit                   quiet       = 1'b0;
  bit                   steady      = 1'b0;
  bit                   hold_off_req = 1'b0;
  int                   requests    = 0;
  int                   settings    = 0;
  logic [SPT_W-1:0]     cur_spt     = SPT_RESET;
  logic [HDS_W-1:0]     cur_heads   = HDS_RESET;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  floppy_rw_command_builder #(
    .BLOCK_WIDTH(BLOCK_W)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .block_i     (block),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cmd_byte_o  (cmd_byte),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  frcb_command_checker #(
    .BLOCK_WIDTH(BLOCK_W)
  ) cmd_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .block_i      (block),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .cmd_byte_i   (cmd_byte),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .bytes_seen_o (bytes_seen)
  );

  task automatic send(input logic wr, input logic [BLOCK_W-1:0] blk);
    if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= wr;
    block    <= blk;
    do @(posedge clk); while (in_stall);
    requests++;
  endtask

  // The checker's count is registered, so the first read follows a fresh edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_geometry(input logic [SPT_W-1:0] spt, input logic [HDS_W-1:0] heads);
    logic [SPT_W-1:0] heads_word;
    heads_word = SPT_W'($urandom);
    heads_word[HDS_W-1:0] = heads;
    wait_drained();
    write_reg(CFG_SPT, spt);
    write_reg(CFG_HEADS, heads_word);
    cfg_valid <= 1'b0;
    cur_spt   = spt;
    cur_heads = heads;
    settings++;
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned cyl;
    int unsigned blk;
    cyl = ((cur_spt == '0) ? 1 : cur_spt) * ((cur_heads == '0) ? 1 : cur_heads);
    case ($urandom_range(0, 5))
      0: blk = 0;
      1: blk = BLOCK_MAX;
      2: blk = $urandom_range(0, 255);
      3: begin
        // Land on the first or last sector of a cylinder.
        blk = $urandom_range(0, BLOCK_MAX / cyl) * cyl;
        if ($urandom_range(0, 1) == 1) blk = blk + cyl - 1;
        if (blk > BLOCK_MAX) blk = BLOCK_MAX;
      end
      default: blk = $urandom_range(0, BLOCK_MAX);
    endcase
    return BLOCK_W'(blk);
  endfunction

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int random_sent;
    int phase;
    int n;
    int directed;
    logic [SPT_W-1:0] spt;
    random_sent = 0;
    phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry of 9 sectors and 2 heads.
    send(OP_READ, 0);
    send(OP_WRITE, BLOCK_MAX);
    send(OP_READ, 17);
    send(OP_WRITE, 18);
    // 18 sectors per track brings in the gap byte.
    set_geometry(6'd18, 2'd2);
    send(OP_WRITE, BLOCK_MAX);
    send(OP_READ, 35);
    send(OP_READ, 36);
    // Zero registers fall back to 1 in the arithmetic.
    set_geometry(6'd0, 2'd0);
    send(OP_READ, 0);
    send(OP_WRITE, BLOCK_MAX);
    send(OP_READ, 5);
    // Three heads: head 2 shows up as 8 in the shifted head byte.
    set_geometry(6'd63, 2'd3);
    send(OP_WRITE, BLOCK_MAX);
    send(OP_READ, 126);
    send(OP_READ, 188);
    // One sector per track and one head: the track number overflows 8 bits.
    set_geometry(6'd1, 2'd1);
    send(OP_READ, BLOCK_MAX);
    send(OP_WRITE, 256);
    set_geometry(6'd63, 2'd1);
    send(OP_READ, 62);
    send(OP_WRITE, 63);
    set_geometry(6'd2, 2'd3);
    send(OP_READ, 4);
    send(OP_WRITE, 5);
    directed = requests;

    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      case (phase)
        1: set_geometry(6'd63, 2'd3);
        2: set_geometry(6'd18, 2'd2);
        3: set_geometry(6'd1, 2'd2);
        4: set_geometry(6'd0, 2'd3);
        default: begin
          case ($urandom_range(0, 7))
            0, 1:    spt = 6'd18;
            2:       spt = 6'd0;
            3:       spt = 6'd63;
            default: spt = SPT_W'($urandom_range(1, 63));
          endcase
          set_geometry(spt, HDS_W'($urandom_range(0, 3)));
        end
      endcase
      if (random_sent >= RANDOM_ITEMS - 50) quiet = 1'b1;
      n = $urandom_range(20, 40);
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      // Back-to-back requests against a long output hold fill the pipeline.
      if (phase == 2) begin
        steady = 1'b1;
        hold_off_req = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        send(1'($urandom_range(0, 1)), pick_block());
        random_sent++;
        if (phase == 1 && i == n / 2) wait_drained();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d directed) over %0d register settings; %0d bytes checked.",
             requests, directed, settings, bytes_seen);
    $display("Covered gap byte, zero registers, three heads and track overflow with stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ floppy_rw_command_builder.f @@
rtl/core/frcb_pkg.sv
rtl/core/floppy_rw_command_builder.sv
verif/frcb_command_checker.sv
verif/tb.sv
